FILE: hdl/tch_pkg.sv
// Shared types, constants and the arctangent table of the heading unit.
`timescale 1ns / 1ps
`default_nettype none
package tch_pkg;
	localparam int DEF_ANGLE_FRAC_BITS = 7;
	localparam int DEF_AXIS_BITS = 16;
	localparam int SW = 18;
	localparam int CW = 52;
	localparam int ZFRAC = 20;
	localparam int CORDIC_STEPS = 23;
	localparam int QDEPTH = 2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TILT = 2'd1;
	localparam logic [1:0] ST_MAG = 2'd2;

	localparam logic signed [31:0] HALF_TURN = 32'sd180 <<< ZFRAC;
	localparam logic signed [31:0] FULL_TURN = 32'sd360 <<< ZFRAC;

	localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121, 32'sd3750058,
		32'sd1876857, 32'sd938658, 32'sd469357, 32'sd234682, 32'sd117342,
		32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
		32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29, 32'sd14
	};

	typedef logic signed [SW-1:0] sval_t;

	typedef struct packed {
		sval_t x;
		sval_t y;
		sval_t z;
	} vec3_t;

	typedef struct packed {
		vec3_t acc;
		vec3_t mag;
		logic [1:0] status;
	} tch_item_t;
endpackage
`default_nettype wire

FILE: hdl/tilt_compensated_heading_unit.sv
// Top level of the tilt-compensated compass heading unit.
//  channel | direction | handshake          | beat content
//  in      | to unit   | in_valid/in_stall  | accel_x/y/z, mag_x/y/z
//  out     | from unit | out_valid/out_stall| heading_deg, status
// A full beat passes through the product steps, 16 square-root steps, a normalize
// loop and 23 CORDIC steps before its result is registered.
// A flagged beat goes from accept straight to the result register.
// The front register and two-entry queue take up to three further beats
// while the engine works. Reset clears all handshake and sequencer state.
`timescale 1ns / 1ps
`default_nettype none
module tilt_compensated_heading_unit import tch_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int AXIS_BITS = DEF_AXIS_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [AXIS_BITS-1:0] accel_x,
	input  wire logic signed [AXIS_BITS-1:0] accel_y,
	input  wire logic signed [AXIS_BITS-1:0] accel_z,
	input  wire logic signed [AXIS_BITS-1:0] mag_x,
	input  wire logic signed [AXIS_BITS-1:0] mag_y,
	input  wire logic signed [AXIS_BITS-1:0] mag_z,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [15:0] heading_deg,
	output logic [1:0] status
);
	logic q_full, q_empty, push, pop;
	tch_item_t push_item, head;

	tch_front #(.AXIS_BITS(AXIS_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
		.q_full(q_full), .push(push), .push_item(push_item)
	);

	tch_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .full(q_full),
		.pop(pop), .empty(q_empty), .head(head)
	);

	tch_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.heading_deg(heading_deg), .status(status)
	);
endmodule
`default_nettype wire

FILE: hdl/tch_front.sv
// Front end: input register, vector scaling and special-case classification.
`timescale 1ns / 1ps
`default_nettype none
module tch_front import tch_pkg::*; #(
	parameter int AXIS_BITS = DEF_AXIS_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [AXIS_BITS-1:0] accel_x,
	input  wire logic signed [AXIS_BITS-1:0] accel_y,
	input  wire logic signed [AXIS_BITS-1:0] accel_z,
	input  wire logic signed [AXIS_BITS-1:0] mag_x,
	input  wire logic signed [AXIS_BITS-1:0] mag_y,
	input  wire logic signed [AXIS_BITS-1:0] mag_z,
	input  wire logic q_full,
	output logic push,
	output tch_item_t push_item
);
	localparam int MW = AXIS_BITS + 17;

	logic valid_s1;
	logic signed [AXIS_BITS-1:0] ax_s1, ay_s1, az_s1, hx_s1, hy_s1, hz_s1;
	vec3_t sa, sh;
	logic a_zero, h_zero;

	function automatic logic [AXIS_BITS-1:0] mag_of(input logic signed [AXIS_BITS-1:0] v);
		return v[AXIS_BITS-1] ? AXIS_BITS'(-v) : AXIS_BITS'(v);
	endfunction

	function automatic sval_t axis_out(input logic [AXIS_BITS-1:0] m, input logic neg,
			input logic [5:0] k, input logic right);
		logic [MW-1:0] mg;
		mg = right ? (MW'(m) >> k) : (MW'(m) << k);
		return neg ? -sval_t'(mg[SW-1:0]) : sval_t'(mg[SW-1:0]);
	endfunction

	function automatic vec3_t scale3(input logic signed [AXIS_BITS-1:0] v0,
			input logic signed [AXIS_BITS-1:0] v1, input logic signed [AXIS_BITS-1:0] v2);
		logic [AXIS_BITS-1:0] m0, m1, m2, mx;
		logic [MW-1:0] me;
		logic [5:0] p, k;
		logic right, left, pow2;
		vec3_t r;
		m0 = mag_of(v0);
		m1 = mag_of(v1);
		m2 = mag_of(v2);
		mx = m0;
		if (m1 > mx) mx = m1;
		if (m2 > mx) mx = m2;
		p = '0;
		for (int i = 0; i < AXIS_BITS; i++) begin
			if (mx[i]) p = 6'(i);
		end
		me = MW'(mx);
		right = me > MW'(32768);
		left = (mx != '0) && (me <= MW'(16384));
		pow2 = (mx & (mx - 1'b1)) == '0;
		k = '0;
		if (right) begin
			k = ((me >> (p - 6'd15)) == MW'(32768)) ? p - 6'd15 : p - 6'd14;
		end else if (left) begin
			k = pow2 ? 6'd15 - p : 6'd14 - p;
		end
		r.x = axis_out(m0, v0[AXIS_BITS-1], k, right);
		r.y = axis_out(m1, v1[AXIS_BITS-1], k, right);
		r.z = axis_out(m2, v2[AXIS_BITS-1], k, right);
		return r;
	endfunction

	assign push = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ax_s1 <= accel_x;
			ay_s1 <= accel_y;
			az_s1 <= accel_z;
			hx_s1 <= mag_x;
			hy_s1 <= mag_y;
			hz_s1 <= mag_z;
		end
	end

	always_comb begin
		sa = scale3(ax_s1, ay_s1, az_s1);
		sh = scale3(hx_s1, hy_s1, hz_s1);
		a_zero = (ax_s1 == '0) && (ay_s1 == '0) && (az_s1 == '0);
		h_zero = (hx_s1 == '0) && (hy_s1 == '0) && (hz_s1 == '0);
		push_item.acc = sa;
		push_item.mag = sh;
		priority if (a_zero) begin
			push_item.status = ST_TILT;
		end else if (sa.y == '0 && sa.z == '0) begin
			push_item.status = ST_TILT;
		end else if (h_zero) begin
			push_item.status = ST_MAG;
		end else begin
			push_item.status = ST_OK;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/tch_queue.sv
// Two-entry queue between the front end and the heading engine.
`timescale 1ns / 1ps
`default_nettype none
module tch_queue import tch_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire tch_item_t push_item,
	output logic full,
	input  wire logic pop,
	output logic empty,
	output tch_item_t head
);
	localparam int PW = $clog2(QDEPTH);

	tch_item_t mem_q [QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;

	assign full = cnt_q == (PW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end
endmodule
`default_nettype wire

FILE: hdl/tch_back.sv
// Heading engine: products, square root, vector normalize, CORDIC and result register.
`timescale 1ns / 1ps
`default_nettype none
module tch_back import tch_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire tch_item_t head,
	output logic pop,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [15:0] heading_deg,
	output logic [1:0] status
);
	localparam int RSH = ZFRAC - ANGLE_FRAC_BITS;
	localparam logic signed [31:0] RND = 32'sd1 <<< (RSH - 1);
	localparam logic signed [31:0] TOP = 32'sd360 <<< ANGLE_FRAC_BITS;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL1 = 9'b000000010,
		S_MUL2 = 9'b000000100,
		S_SQRT = 9'b000001000,
		S_MULY = 9'b000010000,
		S_PREP = 9'b000100000,
		S_NORM = 9'b001000000,
		S_ROT  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q;
	sval_t a0_q, a1_q, a2_q, h0_q, h1_q, h2_q, azm_q;
	logic [1:0] st_q;
	logic zero_q, base_q;
	logic signed [33:0] r2_q, v_q;
	logic signed [35:0] taa_q, taz_q;
	logic signed [CW-1:0] x1_q, x2_q, x3_q, x_q, y_q;
	logic [31:0] rem_q, res_q, bit_q;
	logic [4:0] i_q;
	logic signed [31:0] z_q;
	logic [15:0] head_q;
	logic [1:0] status_q;
	logic res_valid_q;

	logic signed [33:0] sqn;
	logic [31:0] trial;
	sval_t s_val;
	logic signed [CW-1:0] xs, ys, xa, ya, mx;
	logic signed [31:0] ang, q;
	logic fin_go;

	assign sqn = a0_q * a0_q + r2_q;
	assign trial = res_q + bit_q;
	assign s_val = sval_t'({1'b0, res_q[16:0]});
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign xa = x_q[CW-1] ? -x_q : x_q;
	assign ya = y_q[CW-1] ? -y_q : y_q;
	assign mx = (xa > ya) ? xa : ya;
	assign fin_go = (state_q == S_FIN) && (!res_valid_q || !out_stall);
	assign pop = (state_q == S_IDLE) && !q_empty;

	always_comb begin
		ang = (base_q ? HALF_TURN : 32'sd0) + z_q;
		if (ang < 0) ang = ang + FULL_TURN;
		if (ang >= FULL_TURN) ang = ang - FULL_TURN;
		q = (ang + RND) >>> RSH;
		if (q >= TOP) q = q - TOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (fin_go) res_valid_q <= 1'b1;
			else if (!out_stall) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (pop) state_q <= (head.status != ST_OK) ? S_FIN : S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SQRT;
				S_SQRT: if (bit_q[0]) state_q <= S_MULY;
				S_MULY: state_q <= S_PREP;
				S_PREP: state_q <= (x_q == '0 && y_q == '0) ? S_FIN : S_NORM;
				S_NORM: if (mx[CW-1:47] != '0) state_q <= S_ROT;
				S_ROT: if (i_q == 5'(CORDIC_STEPS - 1)) state_q <= S_FIN;
				S_FIN: if (fin_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				a0_q <= head.acc.x;
				a1_q <= head.acc.y;
				a2_q <= head.acc.z;
				azm_q <= head.acc.z[SW-1] ? -head.acc.z : head.acc.z;
				h0_q <= head.mag.x;
				h1_q <= head.mag.y;
				h2_q <= head.mag.z;
				st_q <= head.status;
				zero_q <= head.status != ST_OK;
				base_q <= 1'b0;
			end
			S_MUL1: begin
				r2_q <= a1_q * a1_q + a2_q * a2_q;
				taa_q <= a0_q * a1_q;
				taz_q <= a0_q * azm_q;
				v_q <= -(h2_q * a1_q + h1_q * azm_q);
			end
			S_MUL2: begin
				x1_q <= h0_q * r2_q;
				x2_q <= h1_q * taa_q;
				x3_q <= h2_q * taz_q;
				rem_q <= sqn[31:0];
				res_q <= '0;
				bit_q <= 32'h4000_0000;
			end
			S_SQRT: begin
				x_q <= x1_q - x2_q + x3_q;
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_MULY: y_q <= s_val * v_q;
			S_PREP: begin
				zero_q <= x_q == '0 && y_q == '0;
				if (x_q[CW-1]) begin
					x_q <= -x_q;
					y_q <= -y_q;
					base_q <= 1'b1;
				end
			end
			S_NORM: begin
				i_q <= '0;
				z_q <= '0;
				if (mx[CW-1:47] == '0) begin
					if (mx[CW-1:39] == '0) begin
						x_q <= x_q <<< 8;
						y_q <= y_q <<< 8;
					end else begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end
				end
			end
			S_ROT: begin
				i_q <= i_q + 1'b1;
				if (!y_q[CW-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + ATAN_TAB[i_q];
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - ATAN_TAB[i_q];
				end
			end
			S_FIN: begin
				if (fin_go) begin
					head_q <= zero_q ? 16'd0 : q[15:0];
					status_q <= st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = res_valid_q;
	assign heading_deg = head_q;
	assign status = status_q;
endmodule
`default_nettype wire
